// ===== hdl/ksq_pkg.sv =====
// ----------------------------------------------------------------------------
// ksq_pkg
// shared types, codes and widths of the keyed stable priority queue
// ----------------------------------------------------------------------------
package ksq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int PRIO_W       = 8;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int TDATA_W      = 32;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_REMOVE,
        ST_WAIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          kind;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
    } cell_cmd_t;

endpackage

// ===== hdl/ksq_cell.sv =====
// ----------------------------------------------------------------------------
// ksq_cell
// one slot of the sorted chain: holds an entry, shifts to or from its
// neighbors on insert and removal, and forwards the key search probe
// ----------------------------------------------------------------------------
module ksq_cell #(
    parameter int INDEX = 0,
    parameter int AGE_W = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ksq_pkg::cell_cmd_t            cmd,
    input  logic [AGE_W-1:0]              new_age,
    input  logic [AGE_W-1:0]              victim_pos,
    input  logic [AGE_W-1:0]              victim_age,
    input  logic                          left_after,
    input  logic                          left_valid,
    input  logic [ksq_pkg::KEY_W-1:0]     left_key,
    input  logic [ksq_pkg::PRIO_W-1:0]    left_prio,
    input  logic [AGE_W-1:0]              left_age,
    input  logic                          right_valid,
    input  logic [ksq_pkg::KEY_W-1:0]     right_key,
    input  logic [ksq_pkg::PRIO_W-1:0]    right_prio,
    input  logic [AGE_W-1:0]              right_age,
    input  logic                          probe_in_found,
    input  logic [AGE_W-1:0]              probe_in_age,
    input  logic [AGE_W-1:0]              probe_in_pos,
    input  logic [ksq_pkg::PRIO_W-1:0]    probe_in_prio,
    output logic                          valid,
    output logic [ksq_pkg::KEY_W-1:0]     key,
    output logic [ksq_pkg::PRIO_W-1:0]    prio,
    output logic [AGE_W-1:0]              age,
    output logic                          after,
    output logic                          probe_found,
    output logic [AGE_W-1:0]              probe_age,
    output logic [AGE_W-1:0]              probe_pos,
    output logic [ksq_pkg::PRIO_W-1:0]    probe_prio
);

    logic                       valid_reg, valid_next;
    logic [ksq_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [ksq_pkg::PRIO_W-1:0] prio_reg, prio_next;
    logic [AGE_W-1:0]           age_reg, age_next;

    logic                       pfound_reg, pfound_next;
    logic [AGE_W-1:0]           page_reg, page_next;
    logic [AGE_W-1:0]           ppos_reg, ppos_next;
    logic [ksq_pkg::PRIO_W-1:0] pprio_reg, pprio_next;

    logic                       take_right;
    logic                       src_valid;
    logic [ksq_pkg::KEY_W-1:0]  src_key;
    logic [ksq_pkg::PRIO_W-1:0] src_prio;
    logic [AGE_W-1:0]           src_age;
    logic                       match;

    assign after = valid_reg && (prio_reg <= cmd.prio);

    // removal source: cells at or past the victim pull from the right
    assign take_right = (AGE_W'(INDEX) >= victim_pos);
    assign src_valid  = take_right ? right_valid : valid_reg;
    assign src_key    = take_right ? right_key   : key_reg;
    assign src_prio   = take_right ? right_prio  : prio_reg;
    assign src_age    = take_right ? right_age   : age_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        prio_next  = prio_reg;
        age_next   = age_reg;
        case (cmd.kind)
            ksq_pkg::CELL_INSERT:
            begin
                if (!after)
                begin
                    if (left_after)
                    begin
                        valid_next = 1'b1;
                        key_next   = cmd.key;
                        prio_next  = cmd.prio;
                        age_next   = new_age;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        key_next   = left_key;
                        prio_next  = left_prio;
                        age_next   = left_age;
                    end
                end
            end
            ksq_pkg::CELL_REMOVE:
            begin
                valid_next = src_valid;
                key_next   = src_key;
                prio_next  = src_prio;
                age_next   = (src_age > victim_age) ? src_age - 1'b1 : src_age;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // search probe: keep the newest matching entry seen so far
    assign match = valid_reg && (key_reg == cmd.key)
                   && (!probe_in_found || (age_reg > probe_in_age));

    always_comb
    begin
        if (match)
        begin
            pfound_next = 1'b1;
            page_next   = age_reg;
            ppos_next   = AGE_W'(INDEX);
            pprio_next  = prio_reg;
        end
        else
        begin
            pfound_next = probe_in_found;
            page_next   = probe_in_age;
            ppos_next   = probe_in_pos;
            pprio_next  = probe_in_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            pfound_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            pfound_reg <= pfound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        prio_reg  <= prio_next;
        age_reg   <= age_next;
        page_reg  <= page_next;
        ppos_reg  <= ppos_next;
        pprio_reg <= pprio_next;
    end

    assign valid       = valid_reg;
    assign key         = key_reg;
    assign prio        = prio_reg;
    assign age         = age_reg;
    assign probe_found = pfound_reg;
    assign probe_age   = page_reg;
    assign probe_pos   = ppos_reg;
    assign probe_prio  = pprio_reg;

endmodule

// ===== hdl/keyed_stable_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// keyed_stable_priority_queue_top
// priority queue with stable ties and removal by key, built as a sorted
// chain of cells
// ----------------------------------------------------------------------------
// Entries sit in a chain of CAPACITY cells kept sorted by priority, oldest
// first among equal priorities, so the head cell is always the next to leave.
// For insert, extract, the unused op code and any removal from an empty store,
// the item is latched, then the cells that the op moves all shift one place at
// once. Remove-by-key on a non-empty store first sends a search probe along the
// chain one cell per cycle to find the newest entry with that key, then the cells
// behind it close the gap.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is taken.
module keyed_stable_priority_queue_top #(
    parameter int CAPACITY = ksq_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op, car_number, stay_duration, zero pad
    input  logic [ksq_pkg::TDATA_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, out_number, out_duration, zero pad
    output logic [ksq_pkg::TDATA_W-1:0]   m_tdata
);

    localparam int AGE_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KW    = ksq_pkg::KEY_W;
    localparam int PW    = ksq_pkg::PRIO_W;
    localparam int SW    = ksq_pkg::STATUS_W;
    localparam int OW    = ksq_pkg::OP_W;
    localparam int PAD_W = ksq_pkg::TDATA_W - SW - KW - PW;

    ksq_pkg::state_t state_reg, state_next;

    logic [OW-1:0]    op_reg;
    logic [KW-1:0]    key_reg;
    logic [PW-1:0]    prio_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [AGE_W-1:0] scan_cnt_reg, scan_cnt_next;

    logic          m_tvalid_reg;
    logic [SW-1:0] m_status_reg;
    logic [KW-1:0] m_number_reg;
    logic [PW-1:0] m_duration_reg;

    logic [SW-1:0] hold_status_reg;
    logic [KW-1:0] hold_number_reg;
    logic [PW-1:0] hold_duration_reg;

    logic          res_valid;
    logic [SW-1:0] res_status;
    logic [KW-1:0] res_number;
    logic [PW-1:0] res_duration;
    logic          out_free;
    logic          accept;

    ksq_pkg::cell_cmd_t cmd;
    logic [AGE_W-1:0]   new_age;
    logic [AGE_W-1:0]   victim_pos;
    logic [AGE_W-1:0]   victim_age;

    logic             c_valid [CAPACITY];
    logic [KW-1:0]    c_key   [CAPACITY];
    logic [PW-1:0]    c_prio  [CAPACITY];
    logic [AGE_W-1:0] c_age   [CAPACITY];
    logic             c_after [CAPACITY];
    logic             p_found [CAPACITY];
    logic [AGE_W-1:0] p_age   [CAPACITY];
    logic [AGE_W-1:0] p_pos   [CAPACITY];
    logic [PW-1:0]    p_prio  [CAPACITY];

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ksq_pkg::ST_IDLE);

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic             l_after, l_valid, r_valid, pi_found;
        logic [KW-1:0]    l_key, r_key;
        logic [PW-1:0]    l_prio, r_prio, pi_prio;
        logic [AGE_W-1:0] l_age, r_age, pi_age, pi_pos;

        if (i == 0)
        begin : g_first
            assign l_after  = 1'b1;
            assign l_valid  = 1'b0;
            assign l_key    = '0;
            assign l_prio   = '0;
            assign l_age    = '0;
            assign pi_found = 1'b0;
            assign pi_age   = '0;
            assign pi_pos   = '0;
            assign pi_prio  = '0;
        end
        else
        begin : g_inner
            assign l_after  = c_after[i-1];
            assign l_valid  = c_valid[i-1];
            assign l_key    = c_key[i-1];
            assign l_prio   = c_prio[i-1];
            assign l_age    = c_age[i-1];
            assign pi_found = p_found[i-1];
            assign pi_age   = p_age[i-1];
            assign pi_pos   = p_pos[i-1];
            assign pi_prio  = p_prio[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_key   = '0;
            assign r_prio  = '0;
            assign r_age   = '0;
        end
        else
        begin : g_body
            assign r_valid = c_valid[i+1];
            assign r_key   = c_key[i+1];
            assign r_prio  = c_prio[i+1];
            assign r_age   = c_age[i+1];
        end

        ksq_cell #(
            .INDEX (i),
            .AGE_W (AGE_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .new_age        (new_age),
            .victim_pos     (victim_pos),
            .victim_age     (victim_age),
            .left_after     (l_after),
            .left_valid     (l_valid),
            .left_key       (l_key),
            .left_prio      (l_prio),
            .left_age       (l_age),
            .right_valid    (r_valid),
            .right_key      (r_key),
            .right_prio     (r_prio),
            .right_age      (r_age),
            .probe_in_found (pi_found),
            .probe_in_age   (pi_age),
            .probe_in_pos   (pi_pos),
            .probe_in_prio  (pi_prio),
            .valid          (c_valid[i]),
            .key            (c_key[i]),
            .prio           (c_prio[i]),
            .age            (c_age[i]),
            .after          (c_after[i]),
            .probe_found    (p_found[i]),
            .probe_age      (p_age[i]),
            .probe_pos      (p_pos[i]),
            .probe_prio     (p_prio[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ksq_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = ksq_pkg::ST_EXEC;
            end
            ksq_pkg::ST_EXEC:
            begin
                if ((op_reg == ksq_pkg::OP_REMOVE) && (count_reg != '0))
                    state_next = ksq_pkg::ST_SCAN;
                else if (out_free)
                    state_next = ksq_pkg::ST_IDLE;
                else
                    state_next = ksq_pkg::ST_WAIT;
            end
            ksq_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg == AGE_W'(CAPACITY - 1))
                    state_next = ksq_pkg::ST_REMOVE;
            end
            ksq_pkg::ST_REMOVE:
            begin
                state_next = out_free ? ksq_pkg::ST_IDLE : ksq_pkg::ST_WAIT;
            end
            ksq_pkg::ST_WAIT:
            begin
                if (out_free)
                    state_next = ksq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ksq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        res_valid     = 1'b0;
        res_status    = ksq_pkg::STAT_OK;
        res_number    = '0;
        res_duration  = '0;
        cmd.kind      = ksq_pkg::CELL_HOLD;
        cmd.key       = key_reg;
        cmd.prio      = prio_reg;
        new_age       = count_reg[AGE_W-1:0];
        victim_pos    = '0;
        victim_age    = '0;
        count_next    = count_reg;
        scan_cnt_next = '0;
        unique case (state_reg)
            ksq_pkg::ST_EXEC:
            begin
                unique case (op_reg)
                    ksq_pkg::OP_INSERT:
                    begin
                        res_valid = 1'b1;
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_status = ksq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.kind     = ksq_pkg::CELL_INSERT;
                            count_next   = count_reg + 1'b1;
                            res_number   = key_reg;
                            res_duration = prio_reg;
                        end
                    end
                    ksq_pkg::OP_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_valid  = 1'b1;
                            res_status = ksq_pkg::STAT_EMPTY;
                        end
                    end
                    ksq_pkg::OP_EXTRACT:
                    begin
                        res_valid = 1'b1;
                        if (count_reg == '0)
                        begin
                            res_status = ksq_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.kind     = ksq_pkg::CELL_REMOVE;
                            victim_pos   = '0;
                            victim_age   = c_age[0];
                            count_next   = count_reg - 1'b1;
                            res_number   = c_key[0];
                            res_duration = c_prio[0];
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b1;
                    end
                endcase
            end
            ksq_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            ksq_pkg::ST_REMOVE:
            begin
                res_valid = 1'b1;
                if (p_found[CAPACITY-1])
                begin
                    cmd.kind     = ksq_pkg::CELL_REMOVE;
                    victim_pos   = p_pos[CAPACITY-1];
                    victim_age   = p_age[CAPACITY-1];
                    count_next   = count_reg - 1'b1;
                    res_number   = key_reg;
                    res_duration = p_prio[CAPACITY-1];
                end
                else
                begin
                    res_status = ksq_pkg::STAT_NOT_FOUND;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ksq_pkg::ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            if ((res_valid || (state_reg == ksq_pkg::ST_WAIT)) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tdata[OW-1:0];
            key_reg  <= s_tdata[OW+KW-1:OW];
            prio_reg <= s_tdata[OW+KW+PW-1:OW+KW];
        end
        if (res_valid && out_free)
        begin
            m_status_reg   <= res_status;
            m_number_reg   <= res_number;
            m_duration_reg <= res_duration;
        end
        else if ((state_reg == ksq_pkg::ST_WAIT) && out_free)
        begin
            m_status_reg   <= hold_status_reg;
            m_number_reg   <= hold_number_reg;
            m_duration_reg <= hold_duration_reg;
        end
        if (res_valid && !out_free)
        begin
            hold_status_reg   <= res_status;
            hold_number_reg   <= res_number;
            hold_duration_reg <= res_duration;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_duration_reg, m_number_reg, m_status_reg};

endmodule
